FILE: rtl/core/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, codes and sizes of the video register port.
// ----------------------------------------------------------------------------
`default_nettype none

package vrp_pkg;

  localparam int NtBytesDflt = 2048;
  localparam int SprBytes    = 256;
  localparam int PalBytes    = 32;
  localparam int PatBytes    = 8192;

  localparam int SprAw = $clog2(SprBytes);
  localparam int PalAw = $clog2(PalBytes);
  localparam int PatAw = $clog2(PatBytes);

  // request kinds
  localparam logic [2:0] KIND_RD   = 3'd0;
  localparam logic [2:0] KIND_WR   = 3'd1;
  localparam logic [2:0] KIND_LINE = 3'd2;
  localparam logic [2:0] KIND_VBL  = 3'd3;
  localparam logic [2:0] KIND_NMI  = 3'd4;
  localparam logic [2:0] KIND_PRE  = 3'd5;

  // register indexes
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  localparam logic [13:0] NtLast = 14'h3EFF;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD_STATUS,
    OP_RD_OAM,
    OP_RD_DATA,
    OP_WR_BUS,
    OP_WR_CTRL,
    OP_WR_MASK,
    OP_WR_OAMADDR,
    OP_WR_OAM,
    OP_WR_SCROLL,
    OP_WR_ADDR,
    OP_WR_DATA,
    OP_LINE_END,
    OP_VBL_SET,
    OP_NMI_LINE,
    OP_PRE_LINE
  } op_e;

  typedef enum logic [1:0] {
    SRC_OAM,
    SRC_PAT,
    SRC_NT,
    SRC_PAL
  } src_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi_pulse;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic res_push;
    logic item_pop;
  } back_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/video_register_port_with_vram_core.sv
// results: a request passes the request queue, the execution stage and the
// result queue; sprite and data reads add a registered memory read
// the execution stage takes one request per cycle while the result queue has
// room; sprite and data reads hold it in a wait state before the next request
// reset: a clearing pass sweeps the video memories; full
// stays high until it ends, configuration writes are taken throughout
// ----------------------------------------------------------------------------
// video_register_port_with_vram_core
// Picture processor register port with scroll registers and video memory.
// ----------------------------------------------------------------------------
`default_nettype none

module video_register_port_with_vram_core import vrp_pkg::*; #(
  parameter int NtBytes = NtBytesDflt
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] kind_i,
  input  wire logic [2:0] reg_index_i,
  input  wire logic [7:0] write_data_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      read_data_o,
  output logic            nmi_pulse_o
);

  item_t      item;
  logic       item_empty;
  res_t       res_in, res_out;
  logic       res_full;
  back_stat_t stat;

  assign cfg_ready_o = 1'b1;

  vrp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .reg_index_i (reg_index_i),
    .write_data_i(write_data_i),
    .clearing_i  (stat.clearing),
    .item_pop_i  (stat.item_pop),
    .item_o      (item),
    .item_empty_o(item_empty)
  );

  vrp_back #(
    .NtBytes(NtBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .item_empty_i(item_empty),
    .res_full_i  (res_full),
    .res_o       (res_in),
    .stat_o      (stat)
  );

  vrp_fifo #(
    .Width($bits(res_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (stat.res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign read_data_o = res_out.read_data;
  assign nmi_pulse_o = res_out.nmi_pulse;

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.item_pop |-> !item_empty)
    else $error("operation issued from an empty queue");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> (full && item_empty && !stat.res_push))
    else $error("activity during memory clearing");

endmodule

`default_nettype wire

FILE: rtl/core/vrp_fifo.sv
// ----------------------------------------------------------------------------
// vrp_fifo
// Two-entry queue with registered storage.
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_fifo #(
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vrp_front.sv
// ----------------------------------------------------------------------------
// vrp_front
// Accepts requests, decodes them into operations and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_front import vrp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] kind_i,
  input  wire logic [2:0] reg_index_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic       clearing_i,
  input  wire logic       item_pop_i,
  output item_t           item_o,
  output logic            item_empty_o
);

  item_t item_in;
  logic  q_full;
  op_e   op;

  always_comb begin
    op = OP_NONE;
    unique case (kind_i)
      KIND_RD: begin
        unique case (reg_index_i)
          REG_STATUS:  op = OP_RD_STATUS;
          REG_OAMDATA: op = OP_RD_OAM;
          REG_DATA:    op = OP_RD_DATA;
          default:     op = OP_NONE;
        endcase
      end
      KIND_WR: begin
        unique case (reg_index_i)
          REG_CTRL:    op = OP_WR_CTRL;
          REG_MASK:    op = OP_WR_MASK;
          REG_STATUS:  op = OP_WR_BUS;
          REG_OAMADDR: op = OP_WR_OAMADDR;
          REG_OAMDATA: op = OP_WR_OAM;
          REG_SCROLL:  op = OP_WR_SCROLL;
          REG_ADDR:    op = OP_WR_ADDR;
          REG_DATA:    op = OP_WR_DATA;
          default:     op = OP_NONE;
        endcase
      end
      KIND_LINE: op = OP_LINE_END;
      KIND_VBL:  op = OP_VBL_SET;
      KIND_NMI:  op = OP_NMI_LINE;
      KIND_PRE:  op = OP_PRE_LINE;
      default:   op = OP_NONE;
    endcase
  end

  assign item_in.op   = op;
  assign item_in.data = write_data_i;

  // nothing is taken while the memories are being cleared
  assign full = q_full || clearing_i;

  vrp_fifo #(
    .Width($bits(item_t))
  ) u_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !full),
    .data_i (item_in),
    .full_o (q_full),
    .pop_i  (item_pop_i),
    .data_o (item_o),
    .empty_o(item_empty_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/vrp_back.sv
// ----------------------------------------------------------------------------
// vrp_back
// Executes operations: register state, scroll addresses and video memories.
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_back import vrp_pkg::*; #(
  parameter int NtBytes = NtBytesDflt
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_data_i,
  input  wire item_t      item_i,
  input  wire logic       item_empty_i,
  input  wire logic       res_full_i,
  output res_t            res_o,
  output back_stat_t      stat_o
);

  localparam int NtAw = $clog2(NtBytes);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_RUN   = 3'b010,
    S_WAIT  = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [PatAw-1:0] clr_cnt_q, clr_cnt_d;
  logic [1:0]  mirror_q;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;
  logic        vbl_q, vbl_d;
  logic [7:0]  ob_q, ob_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic        tog_q, tog_d;
  logic [14:0] v_q, v_d;
  logic [14:0] t_q, t_d;
  logic [7:0]  oam_addr_q, oam_addr_d;
  src_e        src_q, src_d;

  logic [7:0] pat_mem [PatBytes];
  logic [7:0] nt_mem  [NtBytes];
  logic [7:0] spr_mem [SprBytes];
  logic [7:0] pal_mem [PalBytes];
  logic [7:0] pat_rd_q, nt_rd_q, spr_rd_q, pal_rd_q;

  logic [13:0]      a;
  logic [13:0]      nt_off, nt_m1;
  logic [13:0]      nt_m2;
  logic [NtAw-1:0]  nt_idx;
  logic [PalAw-1:0] pal_idx;
  src_e             region;
  logic             issue, rendering, clearing;
  logic             res_push;
  logic             pat_we, nt_we, spr_we, pal_we, nmi;
  logic [7:0]       d, pal_val;
  logic [2:0]       fy;
  logic [4:0]       cy;
  logic             nt_y;
  logic [14:0]      vs;
  logic [14:0]      t_wr;

  assign a         = v_q[13:0];
  assign d         = item_i.data;
  assign rendering = (mask_q[4:3] != 2'b00);
  assign clearing  = (state_q == S_CLEAR);

  // nametable mirroring; the direct form wraps with two conditional subtracts
  always_comb begin
    nt_off = a - 14'h2000;
    nt_m1  = (nt_off >= 14'(2 * NtBytes)) ? nt_off - 14'(2 * NtBytes) : nt_off;
    nt_m2  = (nt_m1 >= 14'(NtBytes)) ? nt_m1 - 14'(NtBytes) : nt_m1;
    case (mirror_q)
      2'd0:    nt_idx = NtAw'({3'b000, a[10:0]});
      2'd1:    nt_idx = NtAw'({3'b000, a[11], a[9:0]});
      default: nt_idx = nt_m2[NtAw-1:0];
    endcase
  end

  // palette mirrors of the backdrop entries
  assign pal_idx = {a[4] & (a[1] | a[0]), a[3:0]};

  always_comb begin
    if (!a[13]) begin
      region = SRC_PAT;
    end else if (a <= NtLast) begin
      region = SRC_NT;
    end else begin
      region = SRC_PAL;
    end
  end

  assign pal_val = pal_rd_q & (mask_q[0] ? 8'h30 : 8'hFF);

  // vertical scroll step
  always_comb begin
    fy   = v_q[14:12];
    cy   = v_q[9:5];
    nt_y = v_q[11];
    if (fy != 3'd7) begin
      fy = fy + 3'd1;
    end else begin
      fy = 3'd0;
      if (cy == 5'd31) begin
        cy = 5'd0;
      end else if (cy == 5'd29) begin
        cy   = 5'd0;
        nt_y = ~nt_y;
      end else begin
        cy = cy + 5'd1;
      end
    end
    vs = {fy, nt_y, t_q[10], cy, t_q[4:0]};
  end

  assign t_wr = {t_q[14:8], d};

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    ctrl_d     = ctrl_q;
    mask_d     = mask_q;
    vbl_d      = vbl_q;
    ob_d       = ob_q;
    rbuf_d     = rbuf_q;
    tog_d      = tog_q;
    v_d        = v_q;
    t_d        = t_q;
    oam_addr_d = oam_addr_q;
    src_d      = src_q;
    issue      = 1'b0;
    pat_we     = 1'b0;
    nt_we      = 1'b0;
    spr_we     = 1'b0;
    pal_we     = 1'b0;
    nmi        = 1'b0;
    res_push   = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (!item_empty_i && !res_full_i) begin
          issue = 1'b1;
          res_push = 1'b1;
          if (item_i.op != OP_RD_STATUS && item_i.op != OP_RD_OAM &&
              item_i.op != OP_RD_DATA && item_i.op != OP_NONE &&
              item_i.op != OP_LINE_END && item_i.op != OP_VBL_SET &&
              item_i.op != OP_NMI_LINE && item_i.op != OP_PRE_LINE) begin
            ob_d = d;
          end
          case (item_i.op)
            OP_RD_STATUS: begin
              ob_d  = {vbl_q, 2'b00, ob_q[4:0]};
              vbl_d = 1'b0;
              tog_d = 1'b0;
            end
            OP_RD_OAM: begin
              src_d   = SRC_OAM;
              state_d = S_WAIT;
              res_push = 1'b0;
            end
            OP_RD_DATA: begin
              src_d   = region;
              state_d = S_WAIT;
              res_push = 1'b0;
              v_d = {v_q[14], a + (ctrl_q[2] ? 14'd32 : 14'd1)};
            end
            OP_WR_CTRL: begin
              ctrl_d       = d;
              t_d[11:10]   = d[1:0];
            end
            OP_WR_MASK:    mask_d = d;
            OP_WR_OAMADDR: oam_addr_d = d;
            OP_WR_OAM: begin
              spr_we     = 1'b1;
              oam_addr_d = oam_addr_q + 8'd1;
            end
            OP_WR_SCROLL: begin
              if (!tog_q) begin
                t_d[4:0] = d[7:3];
              end else begin
                t_d[14:12] = d[2:0];
                t_d[9:5]   = d[7:3];
              end
              tog_d = ~tog_q;
            end
            OP_WR_ADDR: begin
              if (!tog_q) begin
                t_d = {1'b0, d[5:0], t_q[7:0]};
              end else begin
                t_d = t_wr;
                v_d = t_wr;
              end
              tog_d = ~tog_q;
            end
            OP_WR_DATA: begin
              pat_we = (region == SRC_PAT);
              nt_we  = (region == SRC_NT);
              pal_we = (region == SRC_PAL);
              v_d = {v_q[14], a + (ctrl_q[2] ? 14'd32 : 14'd1)};
            end
            OP_LINE_END: begin
              if (rendering) begin
                v_d = vs;
              end
            end
            OP_VBL_SET:  vbl_d = 1'b1;
            OP_NMI_LINE: nmi = ctrl_q[7];
            OP_PRE_LINE: begin
              vbl_d = 1'b0;
              if (rendering) begin
                v_d = {t_q[14:11], v_q[10], t_q[9:5], v_q[4:0]};
              end
            end
            default: ;
          endcase
        end
      end
      S_WAIT: begin
        res_push = 1'b1;
        state_d = S_RUN;
        case (src_q)
          SRC_OAM: ob_d = spr_rd_q;
          SRC_PAT: begin
            ob_d   = rbuf_q;
            rbuf_d = pat_rd_q;
          end
          SRC_NT: begin
            ob_d   = rbuf_q;
            rbuf_d = nt_rd_q;
          end
          default: begin
            ob_d   = pal_val;
            rbuf_d = pal_val;
          end
        endcase
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign res_o.read_data = ob_d;
  assign res_o.nmi_pulse = nmi;
  assign stat_o.clearing = clearing;
  assign stat_o.res_push = res_push;
  assign stat_o.item_pop = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      mirror_q   <= 2'd0;
      ctrl_q     <= 8'h00;
      mask_q     <= 8'h00;
      vbl_q      <= 1'b0;
      ob_q       <= 8'h00;
      rbuf_q     <= 8'h00;
      tog_q      <= 1'b0;
      v_q        <= 15'h0000;
      t_q        <= 15'h0000;
      oam_addr_q <= 8'h00;
      src_q      <= SRC_OAM;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      if (cfg_we_i) begin
        mirror_q <= cfg_data_i;
      end
      ctrl_q     <= ctrl_d;
      mask_q     <= mask_d;
      vbl_q      <= vbl_d;
      ob_q       <= ob_d;
      rbuf_q     <= rbuf_d;
      tog_q      <= tog_d;
      v_q        <= v_d;
      t_q        <= t_d;
      oam_addr_q <= oam_addr_d;
      src_q      <= src_d;
    end
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      pat_mem[clr_cnt_q] <= 8'h00;
    end else if (pat_we) begin
      pat_mem[a[PatAw-1:0]] <= d;
    end
    pat_rd_q <= pat_mem[a[PatAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (clearing && (clr_cnt_q < PatAw'(NtBytes))) begin
      nt_mem[clr_cnt_q[NtAw-1:0]] <= 8'hFF;
    end else if (nt_we) begin
      nt_mem[nt_idx] <= d;
    end
    nt_rd_q <= nt_mem[nt_idx];
  end

  always_ff @(posedge clk_i) begin
    if (clearing && (clr_cnt_q < PatAw'(SprBytes))) begin
      spr_mem[clr_cnt_q[SprAw-1:0]] <= 8'h00;
    end else if (spr_we) begin
      spr_mem[oam_addr_q[SprAw-1:0]] <= d;
    end
    spr_rd_q <= spr_mem[oam_addr_q[SprAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (clearing && (clr_cnt_q < PatAw'(PalBytes))) begin
      pal_mem[clr_cnt_q[PalAw-1:0]] <= 8'h00;
    end else if (pal_we) begin
      pal_mem[pal_idx] <= d;
    end
    pal_rd_q <= pal_mem[pal_idx];
  end

endmodule

`default_nettype wire
